// ===== rtl/usm_pkg.sv =====
// Package for the unseen message set: capacity, derived widths,
// operation codes and the item types of both channels.
// No dependencies.
package usm_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int NUM_W    = 32;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_EXPUNGE = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [NUM_W-1:0] msg_num;
  } in_item_t;

  typedef struct packed {
    logic [7:0] entry_count;
    logic       was_present;
    logic       dropped;
  } out_item_t;

endpackage

// ===== rtl/usm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module usm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/unseen_message_set.sv =====
// Top level of the unseen message set.
// Depends on usm_pkg and usm_ram.
//
// Usage:
//   One item on the in_ channel carries an operation (add, remove,
//   expunge, clear) and a message number. Each item gives exactly one
//   result on the out_ channel: the entry count afterwards, whether the
//   number was held, and whether an add was refused because the set is full.
//   Items are handled one at a time. The entries live in one RAM with a
//   registered read; a linear search streams through the held entries at
//   one read per cycle; a removal that frees a slot other than the last
//   moves the last entry into it, and an expunge adds a second pass to
//   renumber. Clear skips the search and goes straight to the result.
//   in_stall is high while an item is in work. A finished result sits in
//   the output register, and the next item is accepted meanwhile; if the
//   receiver keeps stalling, that item waits before its result is loaded.
//   Reset empties the set; RAM contents need no clearing, as only slots
//   below the count are read.
module unseen_message_set
  import usm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MV_RD,
    S_MV_WR,
    S_REN,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             present_r, present_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [NUM_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [NUM_W-1:0] rd_data;

  logic [CNT_W-1:0] last;

  usm_ram #(
    .WIDTH(NUM_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign last      = total_r - CNT_W'(1);

  always_comb begin
    logic found;
    logic [IDX_W-1:0] slot;
    logic resolve;

    state_nxt     = state_r;
    item_nxt      = item_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    slot_nxt      = slot_r;
    present_nxt   = present_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    found         = 1'b0;
    slot          = '0;
    resolve       = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_item;
          present_nxt  = 1'b0;
          dropped_nxt  = 1'b0;
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          if (in_item.kind == KIND_CLEAR) begin
            total_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && rd_data == item_r.msg_num) begin
          found   = 1'b1;
          slot    = pend_idx_r;
          resolve = 1'b1;
        end else if (idx_r < total_r) begin
          rd_en        = 1'b1;
          rd_addr      = idx_r[IDX_W-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt      = idx_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          resolve  = !pend_r;
        end
      end
      S_MV_RD: begin
        rd_en     = 1'b1;
        rd_addr   = total_r[IDX_W-1:0];
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        wr_en    = 1'b1;
        wr_addr  = slot_r;
        wr_data  = rd_data;
        idx_nxt  = '0;
        pend_nxt = 1'b0;
        state_nxt = (item_r.kind == KIND_EXPUNGE) ? S_REN : S_DONE;
      end
      S_REN: begin
        if (pend_r && rd_data > item_r.msg_num) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx_r;
          wr_data = rd_data - NUM_W'(1);
        end
        if (idx_r < total_r) begin
          rd_en        = 1'b1;
          rd_addr      = idx_r[IDX_W-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt      = idx_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.entry_count = 8'(total_r);
          out_item_nxt.was_present = present_r;
          out_item_nxt.dropped     = dropped_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (resolve) begin
      present_nxt = found;
      slot_nxt    = slot;
      pend_nxt    = 1'b0;
      idx_nxt     = '0;
      if (item_r.kind == KIND_ADD) begin
        state_nxt = S_DONE;
        if (!found) begin
          if (total_r < CNT_W'(CAPACITY)) begin
            wr_en     = 1'b1;
            wr_addr   = total_r[IDX_W-1:0];
            wr_data   = item_r.msg_num;
            total_nxt = total_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
        end
      end else begin
        if (found) begin
          total_nxt = last;
        end
        if (found && slot != last[IDX_W-1:0]) begin
          state_nxt = S_MV_RD;
        end else if (item_r.kind == KIND_EXPUNGE) begin
          state_nxt = S_REN;
        end else begin
          state_nxt = S_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    present_r  <= present_nxt;
    dropped_r  <= dropped_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
